// ===== hw/rtl/lzss_pkg.sv =====
// Package for the LZSS byte decompressor: dictionary geometry, field widths,
// token codes and the FSM state type. No dependencies.
`timescale 1ns / 1ps

package lzss_pkg;

  // Dictionary geometry (64 .. 2048 entries, any value)
  localparam int DICT_SIZE = 2048;
  localparam int AW        = $clog2(DICT_SIZE);   // dictionary address width
  localparam int FILL_W    = AW + 1;              // fill count holds DICT_SIZE

  // Stream fields
  localparam int BYTE_W = 8;

  // Copy tokens
  localparam int MAX_LEN = 17;                    // longest copy run
  localparam int LEN_W   = $clog2(MAX_LEN + 1);   // holds 0 .. MAX_LEN
  localparam int BUF_IW  = $clog2(MAX_LEN);       // index into the run buffer
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);

  // Raw position is 11 bits; reduced modulo DICT_SIZE by reciprocal multiply
  localparam int POS_W    = 11;
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / DICT_SIZE;
  localparam int RCP_W    = 11;
  localparam int Q_W      = 6;
  localparam int REM_W    = POS_W + 1;
  localparam logic [REM_W-1:0] DICT_SIZE_R = REM_W'(DICT_SIZE);

  // Token codes
  localparam logic [BYTE_W-1:0] DBL_ESC = 8'hff;  // pair of these is dropped
  localparam logic [3:0]        LIT_NIB = 4'hf;   // partner nibble: literal

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_COPY  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/lzss_if.sv =====
// Stream interfaces of the LZSS decompressor: compressed input and
// decompressed output, valid/ready. Depends on lzss_pkg.
`timescale 1ns / 1ps

interface lzss_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_pkg::BYTE_W-1:0] in_byte;
  logic                      packet_end;

  modport source (output valid, output in_byte, output packet_end, input ready);
  modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

interface lzss_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzss_pkg::BYTE_W-1:0] out_byte;
  logic                      last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/lzss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-before-write data. No dependencies.
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/lzss_byte_decompressor_top.sv =====
// Top level of the LZSS byte decompressor: token decode, copy sequencer and
// output register. Depends on lzss_pkg, lzss_if and lzss_ram.
`timescale 1ns / 1ps

// Takes one compressed byte per request and returns the decompressed bytes,
// the final one of each input flagged with last. A literal shows on the
// output in the cycle after it is accepted; the block takes the following byte
// as soon as the output register is free. A copy token of n bytes (3..17)
// occupies the block from the accept of its second byte through these steps:
// the modulo of the source position, overlap setup, the dictionary read and
// the capture of the byte into the run buffer, then one byte per cycle while
// the output is not stalled, paced by the single read port of the dictionary
// RAM and the output register. When the source run overlaps the bytes the
// copy itself writes, all n bytes are read into the run buffer before the
// first byte goes out. The dictionary needs no clearing after reset: a fill
// count marks which entries were ever written, and the rest read as zero, so
// the block is ready as soon as reset is released.
module lzss_byte_decompressor_top (
  input  logic             clk,
  input  logic             rst_n,
  lzss_in_if.sink          in_ch,
  lzss_out_if.source       out_ch
);

  localparam int AW = lzss_pkg::AW;

  lzss_pkg::state_t state_r, state_nxt;

  logic                          pend_valid_r, pend_valid_nxt;
  logic [lzss_pkg::BYTE_W-1:0]   pend_byte_r, pend_byte_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt, wp_inc;
  logic [lzss_pkg::FILL_W-1:0]   fill_r, fill_nxt;

  logic [lzss_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [lzss_pkg::POS_W-1:0]    pos_raw_r, pos_raw_nxt;
  logic [lzss_pkg::Q_W-1:0]      q_r, q_nxt;
  logic [AW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic                          conflict_r, conflict_nxt;

  logic [lzss_pkg::LEN_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [lzss_pkg::LEN_W-1:0]    cap_cnt_r, cap_cnt_nxt;
  logic [lzss_pkg::LEN_W-1:0]    em_cnt_r, em_cnt_nxt;
  logic                          rd_pend_r, rd_ok_r;
  logic [lzss_pkg::BYTE_W-1:0]   buf_r [lzss_pkg::MAX_LEN];

  logic                          out_valid_r, out_valid_nxt;
  logic [lzss_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_free, in_ready, in_acc;
  logic [lzss_pkg::BYTE_W-1:0]   b;
  logic                          dbl_esc, lit_now, copy_start;
  logic [lzss_pkg::BYTE_W-1:0]   lit_byte;
  logic                          rd_go, rd_ok, em_go, em_last;
  logic [lzss_pkg::BYTE_W-1:0]   em_byte, ram_rdata;
  logic                          wr_en;
  logic [lzss_pkg::BYTE_W-1:0]   wr_data;

  logic [lzss_pkg::RCP_W+lzss_pkg::POS_W-1:0] prod;
  logic [lzss_pkg::REM_W-1:0]    qd, rem0, rem1;
  logic [AW:0]                   diff;
  logic [AW-1:0]                 src_gap;

  // Handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == lzss_pkg::ST_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ready;
  assign b        = in_ch.in_byte;

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last    = out_last_r;

  // Token decode
  assign dbl_esc    = (pend_byte_r == lzss_pkg::DBL_ESC) && (b == lzss_pkg::DBL_ESC);
  assign lit_now    = in_acc && ((!pend_valid_r && !b[7]) ||
                      (pend_valid_r && !dbl_esc && (b[3:0] == lzss_pkg::LIT_NIB)));
  assign copy_start = in_acc && pend_valid_r && !dbl_esc && (b[3:0] != lzss_pkg::LIT_NIB);
  assign lit_byte   = pend_valid_r ? pend_byte_r : b;

  // Ring pointer step
  assign wp_inc = (wp_r == AW'(lzss_pkg::DICT_SIZE - 1)) ? '0 : wp_r + 1'b1;

  // Position modulo: estimate quotient by reciprocal, then one correction
  assign prod = lzss_pkg::RCP_W'(lzss_pkg::RECIP) * pos_raw_nxt;
  assign qd   = lzss_pkg::REM_W'(q_r * lzss_pkg::DICT_SIZE_R);
  assign rem0 = {1'b0, pos_raw_r} - qd;
  assign rem1 = (rem0 >= lzss_pkg::DICT_SIZE_R) ? rem0 - lzss_pkg::DICT_SIZE_R : rem0;

  // Distance from the copy's first write slot back to its source
  always_comb begin
    diff = {1'b0, wp_inc} - {1'b0, rd_addr_r};
    if (diff[AW]) begin
      diff = diff + (AW+1)'(lzss_pkg::DICT_SIZE);
    end
    src_gap = diff[AW-1:0];
  end

  // Copy read side: run ahead of emission into the run buffer
  assign rd_go = (state_r == lzss_pkg::ST_COPY) && (rd_cnt_r < len_r);
  assign rd_ok = {1'b0, rd_addr_r} < fill_r;

  // Copy emit side: on overlap, wait until the whole run is buffered
  assign em_byte = buf_r[em_cnt_r[lzss_pkg::BUF_IW-1:0]];
  assign em_last = em_cnt_r == (len_r - 1'b1);
  assign em_go   = (state_r == lzss_pkg::ST_COPY) && (em_cnt_r < cap_cnt_r) &&
                   (!conflict_r || (cap_cnt_r == len_r)) && out_free;

  assign wr_en   = lit_now || em_go;
  assign wr_data = lit_now ? lit_byte : em_byte;

  lzss_ram #(
    .WIDTH (lzss_pkg::BYTE_W),
    .DEPTH (lzss_pkg::DICT_SIZE)
  ) u_dict (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp_inc),
    .wdata (wr_data),
    .re    (rd_go),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    len_nxt        = len_r;
    pos_raw_nxt    = {pend_byte_r[6:0], b[7:4]};
    q_nxt          = q_r;
    rd_addr_nxt    = rd_addr_r;
    conflict_nxt   = conflict_r;
    rd_cnt_nxt     = rd_cnt_r;
    cap_cnt_nxt    = cap_cnt_r;
    em_cnt_nxt     = em_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;

    // pending high-bit byte
    if (in_acc) begin
      if (!pend_valid_r) begin
        if (b[7] && !in_ch.packet_end) begin
          pend_valid_nxt = 1'b1;
          pend_byte_nxt  = b;
        end
      end else begin
        pend_valid_nxt = 1'b0;
      end
    end

    unique case (state_r)
      lzss_pkg::ST_IDLE: begin
        if (copy_start) begin
          len_nxt   = {1'b0, b[3:0]} + lzss_pkg::LEN_BIAS;
          q_nxt     = prod[lzss_pkg::RECIP_SH +: lzss_pkg::Q_W];
          state_nxt = lzss_pkg::ST_DIV;
        end
      end
      lzss_pkg::ST_DIV: begin
        rd_addr_nxt = rem1[AW-1:0];
        state_nxt   = lzss_pkg::ST_SETUP;
      end
      lzss_pkg::ST_SETUP: begin
        conflict_nxt = (src_gap != '0) && ({1'b0, src_gap} < (AW+1)'(len_r));
        rd_cnt_nxt   = '0;
        cap_cnt_nxt  = '0;
        em_cnt_nxt   = '0;
        state_nxt    = lzss_pkg::ST_COPY;
      end
      lzss_pkg::ST_COPY: begin
        if (rd_go) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          rd_addr_nxt = (rd_addr_r == AW'(lzss_pkg::DICT_SIZE - 1)) ? '0 : rd_addr_r + 1'b1;
        end
        if (rd_pend_r) begin
          cap_cnt_nxt = cap_cnt_r + 1'b1;
        end
        if (em_go) begin
          em_cnt_nxt = em_cnt_r + 1'b1;
          if (em_last) begin
            state_nxt = lzss_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lzss_pkg::ST_IDLE;
    endcase

    // output register
    if (wr_en) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = wr_data;
      out_last_nxt  = lit_now ? 1'b1 : em_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Dictionary pointer and fill count
  always_comb begin
    wp_nxt   = wr_en ? wp_inc : wp_r;
    fill_nxt = fill_r;
    if (wr_en && (fill_r != lzss_pkg::FILL_W'(lzss_pkg::DICT_SIZE))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzss_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
      wp_r         <= AW'(lzss_pkg::DICT_SIZE - 1);
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_cnt_r     <= '0;
      cap_cnt_r    <= '0;
      em_cnt_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= rd_go;
      rd_cnt_r     <= rd_cnt_nxt;
      cap_cnt_r    <= cap_cnt_nxt;
      em_cnt_r     <= em_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    len_r       <= len_nxt;
    pos_raw_r   <= pos_raw_nxt;
    q_r         <= q_nxt;
    rd_addr_r   <= rd_addr_nxt;
    conflict_r  <= conflict_nxt;
    rd_ok_r     <= rd_ok;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Run buffer: never-written dictionary entries read as zero
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      buf_r[cap_cnt_r[lzss_pkg::BUF_IW-1:0]] <= rd_ok_r ? ram_rdata : '0;
    end
  end

endmodule

// ===== hw/rtl/lzss_checker.sv =====
// Port-level checker for the LZSS byte decompressor, bound to the top level.
// Depends on lzss_pkg and lzss_byte_decompressor_top.
`timescale 1ns / 1ps

module lzss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lzss_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  // a waiting result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

  // a new input request is only taken when the output register frees up
  a_in_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken while output register is full");

  // mid-run of a copy the input stays closed
  a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a copy run");

endmodule

bind lzss_byte_decompressor_top lzss_checker u_lzss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

// ===== tb/lzss_byte_decompressor_top_tb.sv =====
// Testbench for lzss_byte_decompressor_top: directed token cases, then random token streams
// with random stalls on both sides and a stall-free tail, checked against a built-in decoder mirror.
// Depends on lzss_pkg, lzss_if and the RTL of the decompressor.
`timescale 1ns / 1ps

module lzss_byte_decompressor_top_tb;

  localparam int ITEM_TARGET    = 400;
  localparam int DRAIN_AT       = 200;
  localparam int QUIET_AT       = 340;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [lzss_pkg::BYTE_W-1:0] data;
    logic                        last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  lzss_byte_decompressor_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder mirror: dictionary, write pointer, held high-bit byte
  logic [lzss_pkg::BYTE_W-1:0] dict_mirror [lzss_pkg::DICT_SIZE];
  logic [lzss_pkg::AW-1:0]     wr_ptr_mirror;
  logic                        held_valid;
  logic [lzss_pkg::BYTE_W-1:0] held_byte;
  out_beat_t                   expected_bytes [$];

  int  items_sent;
  int  mismatch_count;
  bit  idle_enable;

  function automatic void clear_mirror();
    for (int i = 0; i < lzss_pkg::DICT_SIZE; i++) dict_mirror[i] = '0;
    wr_ptr_mirror = lzss_pkg::AW'(lzss_pkg::DICT_SIZE - 1);
    held_valid    = 1'b0;
    held_byte     = '0;
  endfunction

  // Every produced byte goes out and into the ring
  function automatic void emit_byte(input logic [lzss_pkg::BYTE_W-1:0] b,
                                    input logic is_last);
    out_beat_t beat;
    wr_ptr_mirror = lzss_pkg::AW'((int'(wr_ptr_mirror) + 1) % lzss_pkg::DICT_SIZE);
    dict_mirror[wr_ptr_mirror] = b;
    beat.data = b;
    beat.last = is_last;
    expected_bytes.push_back(beat);
  endfunction

  // Decode one accepted compressed byte into its expected output bytes
  function automatic void decode_byte(input logic [lzss_pkg::BYTE_W-1:0] b,
                                      input logic pkt_end);
    logic [lzss_pkg::BYTE_W-1:0] hi;
    logic [lzss_pkg::BYTE_W-1:0] run [lzss_pkg::MAX_LEN];
    int                          run_len;
    int                          src;
    if (!held_valid) begin
      if (!b[7]) emit_byte(b, 1'b1);
      else if (!pkt_end) begin
        held_valid = 1'b1;
        held_byte  = b;
      end
      return;
    end
    hi         = held_byte;
    held_valid = 1'b0;
    held_byte  = '0;
    if (hi == lzss_pkg::DBL_ESC && b == lzss_pkg::DBL_ESC) return;
    if (b[3:0] == lzss_pkg::LIT_NIB) begin
      emit_byte(hi, 1'b1);
      return;
    end
    run_len = int'(b[3:0]) + 3;
    src     = int'({hi[6:0], b[7:4]}) % lzss_pkg::DICT_SIZE;
    // snapshot first: an overlapping run reads pre-copy contents
    for (int i = 0; i < run_len; i++) begin
      run[i] = dict_mirror[src];
      src    = (src + 1) % lzss_pkg::DICT_SIZE;
    end
    for (int i = 0; i < run_len; i++) emit_byte(run[i], i == run_len - 1);
  endfunction

  // One request on the input channel; entered and left at a falling edge
  task automatic send_byte(input logic [lzss_pkg::BYTE_W-1:0] b, input logic pkt_end);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.packet_end <= pkt_end;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, pkt_end);
    items_sent++;
    @(negedge clk);
  endtask

  // Copy token: nib must be 0..14
  task automatic send_copy(input logic [lzss_pkg::POS_W-1:0] pos, input logic [3:0] nib,
                           input logic pkt_end);
    send_byte({1'b1, pos[10:4]}, 1'b0);
    send_byte({pos[3:0], nib}, pkt_end);
  endtask

  // High-bit literal via a partner with low nibble 15
  task automatic send_escaped(input logic [lzss_pkg::BYTE_W-1:0] hi,
                              input logic [3:0] hi_nib, input logic pkt_end);
    send_byte(hi, 1'b0);
    send_byte({hi_nib, lzss_pkg::LIT_NIB}, pkt_end);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  // Plain literals at both ends of the 7-bit range
  task automatic test_literals();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h2a, 1'b0);
  endtask

  // Escaped literals, double escape, filler, pending byte across a packet end
  task automatic test_escapes();
    send_escaped(8'h80, 4'h0, 1'b0);
    send_escaped(8'hff, 4'ha, 1'b1);
    send_byte(lzss_pkg::DBL_ESC, 1'b0);
    send_byte(lzss_pkg::DBL_ESC, 1'b0);
    send_byte(8'h9c, 1'b1);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h5f, 1'b1);
  endtask

  // Shortest and longest runs, top position with wrap, run overlapping its own writes
  task automatic test_copies();
    logic [lzss_pkg::POS_W-1:0] pos;
    send_copy(11'd0, 4'd0, 1'b0);
    send_copy(11'h7ff, 4'd14, 1'b1);
    pos = lzss_pkg::POS_W'((int'(wr_ptr_mirror) + lzss_pkg::DICT_SIZE - 1) %
                           lzss_pkg::DICT_SIZE);
    send_copy(pos, 4'd14, 1'b1);
  endtask

  // Mostly well-formed tokens with random content, some noise
  task automatic test_random_stream(input int stop_at);
    int                         pick;
    logic [lzss_pkg::POS_W-1:0] pos;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte({1'b0, 7'($urandom_range(0, 127))}, $urandom_range(0, 7) == 0);
      end else if (pick < 65) begin
        if ($urandom_range(0, 3) == 0) pos = lzss_pkg::POS_W'($urandom_range(0, 2047));
        else pos = lzss_pkg::POS_W'((int'(wr_ptr_mirror) + lzss_pkg::DICT_SIZE -
                                     $urandom_range(0, 40)) % lzss_pkg::DICT_SIZE);
        send_copy(pos, 4'($urandom_range(0, 14)), $urandom_range(0, 3) == 0);
      end else if (pick < 75) begin
        send_escaped({1'b1, 7'($urandom_range(0, 127))}, 4'($urandom_range(0, 15)),
                     $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        send_byte(lzss_pkg::DBL_ESC, 1'b0);
        send_byte(lzss_pkg::DBL_ESC, 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Sender holds off until every pending output byte is out
  task automatic test_drain_pause();
    wait_drained();
    send_copy(lzss_pkg::POS_W'((int'(wr_ptr_mirror) + lzss_pkg::DICT_SIZE - 8) %
                               lzss_pkg::DICT_SIZE), 4'd5, 1'b0);
  endtask

  // Full-rate tail: no gaps on either side
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    test_random_stream(ITEM_TARGET);
  endtask

  // Main sequence
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.packet_end = 1'b0;
    items_sent       = 0;
    mismatch_count   = 0;
    idle_enable      = 1'b1;
    clear_mirror();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_literals();
    test_escapes();
    test_copies();
    test_random_stream(DRAIN_AT);
    test_drain_pause();
    test_random_stream(QUIET_AT);
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Output backpressure in random bursts
  initial begin : out_stall
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void note_mismatch(input string what, input out_beat_t want,
                                        input out_beat_t got);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.data, want.last, got.data, got.last);
    mismatch_count++;
  endfunction

  // Compare each output request with the oldest expected byte
  always @(posedge clk) begin : check_output
    out_beat_t want;
    out_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.out_byte;
      got.last = out_ch.last;
      if (expected_bytes.size() == 0) begin
        want = '0;
        note_mismatch("unexpected output", want, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.last !== want.last)
          note_mismatch("output mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
